// ===== src/ssag_pkg.sv =====
// Shared types and constants of the strided slice address generator.
package ssag_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RANK         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_COUNTS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_BEGINS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_STRIDES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_STR_LO   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_STR_HI   = 3'd5;

    // Register layout
    localparam int RANK_W       = 3;
    localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;
    localparam int PACKED_AXES  = 4;
    localparam int AXIS_FIELD_W = 16;
    localparam int SRC_STRIDE_W = 32;

    // Width of one partial product operand in the scaling multiplier
    localparam int MUL_CHUNK_W  = 32;

    // Output field widths
    localparam int OUT_INDEX_W  = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_TERM,
        ST_SUM,
        ST_DONE
    } t_state;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic clear;    // zero the axis counter
        logic advance;  // step the odometer
        logic ld_prod;  // load position = begin + counter * stride
        logic ld_term;  // one partial product step of position * source stride
        logic ld_acc;   // pass the running sum one cell outward
    } t_cell_ctrl;

endpackage

// ===== src/strided_slice_address_gen_unit.sv =====
// Top level: configuration registers, sequencer, chain of axis cells, output register.
// A transaction steps through the states PROD, TERM, SUM and DONE before its result is registered;
// a new transaction is accepted only in IDLE, once the previous result has left DONE. The pace is
// set by the sum passing through one cell per cycle and the 32-bit chunked scaling multiply.
// Reset (synchronous, active low): counters, destination position and handshake state clear;
// rank resets to 4, all other configuration registers to zero.
module strided_slice_address_gen_unit #(
    parameter int MAX_RANK    = 4,
    parameter int COUNT_WIDTH = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [ssag_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ssag_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] restart, [7:1] zero
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata,  // [31:0] src_index, [63:32] dst_index
    output logic                               m_axis_tlast
);
    import ssag_pkg::*;

    localparam int NPP    = (INDEX_WIDTH + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int CNTW   = $clog2(NPP + MAX_RANK + 1);
    localparam int IDXO   = (INDEX_WIDTH < OUT_INDEX_W) ? INDEX_WIDTH : OUT_INDEX_W;

    // Configuration registers
    logic [RANK_W-1:0]     r_rank;
    logic [CFG_DATA_W-1:0] r_counts, r_begins, r_strides, r_src_lo, r_src_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank    <= RANK_RESET;
            r_counts  <= '0;
            r_begins  <= '0;
            r_strides <= '0;
            r_src_lo  <= '0;
            r_src_hi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RANK:         r_rank    <= i_cfg_data[RANK_W-1:0];
                REG_AXIS_COUNTS:  r_counts  <= i_cfg_data;
                REG_AXIS_BEGINS:  r_begins  <= i_cfg_data;
                REG_AXIS_STRIDES: r_strides <= i_cfg_data;
                REG_SRC_STR_LO:   r_src_lo  <= i_cfg_data;
                REG_SRC_STR_HI:   r_src_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective rank: zero acts as one, saturate to MAX_RANK and to the packed axes
    logic [3:0] act_rank;
    always_comb begin
        act_rank = {1'b0, r_rank};
        if (act_rank == 4'd0) begin
            act_rank = 4'd1;
        end
        if (act_rank > 4'(MAX_RANK)) begin
            act_rank = 4'(MAX_RANK);
        end
        if (act_rank > 4'(PACKED_AXES)) begin
            act_rank = 4'(PACKED_AXES);
        end
    end

    // Sequencer
    t_state           r_state, n_state;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             r_out_valid;
    logic             s_fire, done_fire, restart, chain_last;
    t_cell_ctrl       ctrl;

    assign restart   = s_axis_tdata[0];
    assign s_fire    = s_axis_tvalid & s_axis_tready;
    assign done_fire = (r_state == ST_DONE) & (!r_out_valid | m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_fire) n_state = ST_PROD;
            ST_PROD: n_state = ST_TERM;
            ST_TERM: if (r_cnt == CNTW'(NPP - 1)) n_state = ST_SUM;
            ST_SUM:  if (r_cnt == CNTW'(MAX_RANK - 1)) n_state = ST_DONE;
            ST_DONE: if (done_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Step counter restarts on every state change
    assign n_cnt = (n_state != r_state) ? '0 : r_cnt + CNTW'(1);

    always_comb begin
        s_axis_tready = 1'b0;
        ctrl          = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ctrl.clear    = s_fire & restart;
            end
            ST_PROD: ctrl.ld_prod = 1'b1;
            ST_TERM: ctrl.ld_term = 1'b1;
            ST_SUM:  ctrl.ld_acc  = 1'b1;
            ST_DONE: begin
                ctrl.clear   = done_fire & chain_last;
                ctrl.advance = done_fire & !chain_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Chain of axis cells, axis 0 innermost
    logic [MAX_RANK:0]                  carry_link, last_link;
    logic [INDEX_WIDTH-1:0]             acc_link [MAX_RANK+1];

    assign carry_link[0] = 1'b1;
    assign last_link[0]  = 1'b1;
    assign acc_link[0]   = '0;

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_cell
        logic [AXIS_FIELD_W-1:0] count_f, begin_f, stride_f;
        logic [SRC_STRIDE_W-1:0] src_f;

        if (k < 2) begin : g_lo
            assign src_f = r_src_lo[SRC_STRIDE_W*k +: SRC_STRIDE_W];
        end else if (k < PACKED_AXES) begin : g_hi
            assign src_f = r_src_hi[SRC_STRIDE_W*(k-2) +: SRC_STRIDE_W];
        end else begin : g_none
            assign src_f = '0;
        end

        if (k < PACKED_AXES) begin : g_fld
            assign count_f  = r_counts[AXIS_FIELD_W*k +: AXIS_FIELD_W];
            assign begin_f  = r_begins[AXIS_FIELD_W*k +: AXIS_FIELD_W];
            assign stride_f = r_strides[AXIS_FIELD_W*k +: AXIS_FIELD_W];
        end else begin : g_nofld
            assign count_f  = '0;
            assign begin_f  = '0;
            assign stride_f = '0;
        end

        ssag_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .INDEX_WIDTH (INDEX_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_active     (4'(k) < act_rank),
            .i_count      (count_f),
            .i_begin      (begin_f),
            .i_stride     (stride_f),
            .i_src_stride (src_f),
            .i_carry      (carry_link[k]),
            .i_last       (last_link[k]),
            .i_acc        (acc_link[k]),
            .o_carry      (carry_link[k+1]),
            .o_last       (last_link[k+1]),
            .o_acc        (acc_link[k+1])
        );
    end

    assign chain_last = last_link[MAX_RANK];

    // Destination position
    logic [OUT_INDEX_W-1:0] r_dest;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= '0;
        end else if (ctrl.clear) begin
            r_dest <= '0;
        end else if (ctrl.advance) begin
            r_dest <= r_dest + OUT_INDEX_W'(1);
        end
    end

    // Output register
    logic [OUT_INDEX_W-1:0] r_src_out, r_dst_out;
    logic                   r_last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_src_out  <= OUT_INDEX_W'(acc_link[MAX_RANK][IDXO-1:0]);
            r_dst_out  <= OUT_INDEX_W'(r_dest[IDXO-1:0]);
            r_last_out <= chain_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_dst_out, r_src_out};
    assign m_axis_tlast  = r_last_out;

endmodule

// ===== src/ssag_cell.sv =====
// One axis cell: counter, position/term arithmetic, odometer carry and sum link.
module ssag_cell #(
    parameter int COUNT_WIDTH = 16,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssag_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_active,
    input  logic [ssag_pkg::AXIS_FIELD_W-1:0] i_count,
    input  logic [ssag_pkg::AXIS_FIELD_W-1:0] i_begin,
    input  logic [ssag_pkg::AXIS_FIELD_W-1:0] i_stride,
    input  logic [ssag_pkg::SRC_STRIDE_W-1:0] i_src_stride,
    input  logic                              i_carry,
    input  logic                              i_last,
    input  logic [INDEX_WIDTH-1:0]            i_acc,
    output logic                              o_carry,
    output logic                              o_last,
    output logic [INDEX_WIDTH-1:0]            o_acc
);
    import ssag_pkg::*;

    localparam int PW   = COUNT_WIDTH + 1 + AXIS_FIELD_W;
    localparam int EW   = INDEX_WIDTH + PW;
    localparam int NPP  = (INDEX_WIDTH + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int PADW = NPP * MUL_CHUNK_W;

    logic [COUNT_WIDTH-1:0]   r_counter, n_counter;
    logic [PADW-1:0]          r_pos, n_pos;
    logic [PADW-1:0]          r_term, n_term;
    logic [INDEX_WIDTH-1:0]   r_acc, n_acc;

    logic [COUNT_WIDTH-1:0]   ext_raw, extent, nxt;
    logic [COUNT_WIDTH:0]     inc;
    logic                     at_end, wrap;
    logic signed [PW-1:0]     prod;
    logic signed [EW-1:0]     prod_ext;
    logic [INDEX_WIDTH-1:0]   pos;
    logic [MUL_CHUNK_W-1:0]   chunk;
    logic [2*MUL_CHUNK_W-1:0] pp;

    // Extent of the axis, zero acting as one
    assign ext_raw = COUNT_WIDTH'(i_count);
    assign extent  = (ext_raw == '0) ? COUNT_WIDTH'(1) : ext_raw;

    // Last-element test and odometer wrap
    assign inc     = {1'b0, r_counter} + (COUNT_WIDTH+1)'(1);
    assign at_end  = !(inc < {1'b0, extent});
    assign nxt     = inc[COUNT_WIDTH-1:0];
    assign wrap    = !(nxt < extent);
    assign o_last  = i_last & (!i_active | at_end);
    assign o_carry = i_carry & i_active & wrap;

    // Position along the source axis, modulo 2^INDEX_WIDTH
    assign prod     = PW'($signed({1'b0, r_counter})) * PW'($signed(i_stride));
    assign prod_ext = EW'(prod);
    assign pos      = INDEX_WIDTH'(i_begin) + prod_ext[INDEX_WIDTH-1:0];

    // Scaling by the source stride, top chunk first (Horner form)
    assign chunk = r_pos[PADW-1 -: MUL_CHUNK_W];
    assign pp    = (2*MUL_CHUNK_W)'(chunk) * (2*MUL_CHUNK_W)'(i_src_stride);

    always_comb begin
        n_counter = r_counter;
        if (i_ctrl.clear) begin
            n_counter = '0;
        end else if (i_ctrl.advance && i_active && i_carry) begin
            n_counter = wrap ? '0 : nxt;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_term = r_term;
        if (i_ctrl.ld_prod) begin
            n_pos  = PADW'(pos);
            n_term = '0;
        end else if (i_ctrl.ld_term) begin
            n_pos  = r_pos << MUL_CHUNK_W;
            n_term = (r_term << MUL_CHUNK_W) + PADW'(pp);
        end
    end

    // Running sum link; inactive axes add nothing
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.ld_acc) begin
            n_acc = i_acc + (i_active ? r_term[INDEX_WIDTH-1:0] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_term <= n_term;
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== tb/sv/ssag_slice_checker.sv =====
// Checker for the strided slice address generator: tracks registers, predicts and compares.
module ssag_slice_checker #(
    parameter int MAX_RANK = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssag_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ssag_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [7:0]                       i_in_data,   // [0] restart, [7:1] zero
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [63:0]                      i_out_data,  // [31:0] src_index, [63:32] dst_index
    input  logic                             i_out_last,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_elem_count,
    output int                               o_last_count
);
    import ssag_pkg::*;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] src_index;
        logic [OUT_INDEX_W-1:0] dst_index;
        logic                   last;
    } t_slice_elem;

    // Shadow copy of the register file
    logic [RANK_W-1:0]     rank_q;
    logic [CFG_DATA_W-1:0] counts_q;
    logic [CFG_DATA_W-1:0] begins_q;
    logic [CFG_DATA_W-1:0] strides_q;
    logic [CFG_DATA_W-1:0] src_lo_q;
    logic [CFG_DATA_W-1:0] src_hi_q;

    // Odometer position of the next element and its destination index
    logic [AXIS_FIELD_W-1:0] odo_pos [PACKED_AXES];
    logic [OUT_INDEX_W-1:0]  dst_next;

    t_slice_elem elem_q [$];
    int          n_fail = 0;
    int          n_elem = 0;
    int          n_last = 0;

    // Extent of one axis; zero behaves as one
    function automatic logic [16:0] axis_extent(input int k);
        logic [AXIS_FIELD_W-1:0] c;
        c = counts_q[AXIS_FIELD_W*k +: AXIS_FIELD_W];
        return (c == '0) ? 17'd1 : {1'b0, c};
    endfunction

    function automatic logic [SRC_STRIDE_W-1:0] src_stride(input int k);
        if (k < 2)
            return src_lo_q[SRC_STRIDE_W*k +: SRC_STRIDE_W];
        else
            return src_hi_q[SRC_STRIDE_W*(k-2) +: SRC_STRIDE_W];
    endfunction

    function automatic void clear_odometer();
        for (int k = 0; k < PACKED_AXES; k++)
            odo_pos[k] = '0;
        dst_next = '0;
    endfunction

    // Compute the element addressed now, then step the odometer
    function automatic t_slice_elem next_slice_elem(input logic restart);
        t_slice_elem             e;
        int                      n_axes;
        logic [OUT_INDEX_W-1:0]  acc;
        logic [OUT_INDEX_W-1:0]  pos;
        logic [OUT_INDEX_W-1:0]  stride_sx;
        logic [AXIS_FIELD_W-1:0] step;
        logic                    carry;
        logic                    at_end;
        n_axes = (rank_q == '0) ? 1 : int'(rank_q);
        if (n_axes > MAX_RANK)
            n_axes = MAX_RANK;
        if (n_axes > PACKED_AXES)
            n_axes = PACKED_AXES;
        if (restart)
            clear_odometer();
        acc    = '0;
        at_end = 1'b1;
        for (int k = 0; k < n_axes; k++) begin
            stride_sx = {{16{strides_q[AXIS_FIELD_W*k + 15]}},
                         strides_q[AXIS_FIELD_W*k +: AXIS_FIELD_W]};
            pos = 32'(begins_q[AXIS_FIELD_W*k +: AXIS_FIELD_W]) + 32'(odo_pos[k]) * stride_sx;
            acc = acc + pos * src_stride(k);
            if (32'(odo_pos[k]) + 32'd1 < 32'(axis_extent(k)))
                at_end = 1'b0;
        end
        e.src_index = acc;
        e.dst_index = dst_next;
        e.last      = at_end;
        if (at_end) begin
            clear_odometer();
        end else begin
            // innermost axis first; a wrap carries outward
            carry = 1'b1;
            for (int k = 0; k < n_axes; k++) begin
                if (carry) begin
                    step = odo_pos[k] + 16'd1;
                    if ({1'b0, step} < axis_extent(k)) begin
                        odo_pos[k] = step;
                        carry      = 1'b0;
                    end else begin
                        odo_pos[k] = '0;
                    end
                end
            end
            dst_next = dst_next + 32'd1;
        end
        return e;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            n_fail++;
        end
    endfunction

    // Watch the register port and both streams
    always @(posedge i_clk) begin
        t_slice_elem want;
        if (!i_rst_n) begin
            rank_q    = RANK_RESET;
            counts_q  = '0;
            begins_q  = '0;
            strides_q = '0;
            src_lo_q  = '0;
            src_hi_q  = '0;
            clear_odometer();
            elem_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANK:         rank_q    = i_cfg_data[RANK_W-1:0];
                    REG_AXIS_COUNTS:  counts_q  = i_cfg_data;
                    REG_AXIS_BEGINS:  begins_q  = i_cfg_data;
                    REG_AXIS_STRIDES: strides_q = i_cfg_data;
                    REG_SRC_STR_LO:   src_lo_q  = i_cfg_data;
                    REG_SRC_STR_HI:   src_hi_q  = i_cfg_data;
                    default: ;
                endcase
            end
            // result side: compare against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                n_elem++;
                if (i_out_last)
                    n_last++;
                if (elem_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual src %h dst %h last %b",
                             $time, i_out_data[31:0], i_out_data[63:32], i_out_last);
                    n_fail++;
                end else begin
                    want = elem_q.pop_front();
                    check_field("src_index", want.src_index, i_out_data[31:0]);
                    check_field("dst_index", want.dst_index, i_out_data[63:32]);
                    check_field("last", 32'(want.last), 32'(i_out_last));
                end
            end
            // request side: predict the element this transaction produces
            if (i_in_valid && i_in_ready)
                elem_q.insert(elem_q.size(), next_slice_elem(i_in_data[0]));
        end
        o_pending    <= elem_q.size();
        o_fail_count <= n_fail;
        o_elem_count <= n_elem;
        o_last_count <= n_last;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, register setup, request and result traffic, verdict.
module tb_top;
    import ssag_pkg::*;

    localparam int MAX_RANK     = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 12;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 100;
    localparam int RUN_LIMIT    = 4_000_000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [0] restart, [7:1] zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [63:0]            m_axis_tdata;         // [31:0] src_index, [63:32] dst_index
    logic                   m_axis_tlast;

    int fail_count;
    int pending;
    int elem_count;
    int last_count;
    int n_settings    = 0;
    bit send_no_idle  = 1'b0;
    bit recv_no_idle  = 1'b0;
    bit hold_req      = 1'b0;

    strided_slice_address_gen_unit #(
        .MAX_RANK(MAX_RANK)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    ssag_slice_checker #(
        .MAX_RANK(MAX_RANK)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_elem_count (elem_count),
        .o_last_count (last_count)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // One register write per cycle; write enable drops after the last one
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic write_regs(input logic [2:0] rank, input logic [63:0] counts,
                              input logic [63:0] begins, input logic [63:0] strides,
                              input logic [63:0] src_lo, input logic [63:0] src_hi);
        cfg_write(REG_RANK, 64'(rank));
        cfg_write(REG_AXIS_COUNTS, counts);
        cfg_write(REG_AXIS_BEGINS, begins);
        cfg_write(REG_AXIS_STRIDES, strides);
        cfg_write(REG_SRC_STR_LO, src_lo);
        cfg_write(REG_SRC_STR_HI, src_hi);
        cfg_we <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // Offer one request after a random gap and wait for its transaction
    task automatic send_elem(input logic restart);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Result sink: random stalls per result, or one long hold-off on request
    initial begin : result_sink
        int n;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                n         = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                n = recv_no_idle ? 0 : $urandom_range(0, 10);
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin : stimulus
        logic [63:0] counts;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, advancing without a restart: every element is the last
        repeat (3) send_elem(1'b0);
        drain();

        // Rank zero acts as one; most negative stride; full source stride
        write_regs(3'd0, {48'hFFFF_FFFF_FFFF, 16'd3}, {48'd0, 16'hFFFF},
                   {48'd0, 16'h8000}, {32'd0, 32'hFFFF_FFFF}, 64'd0);
        send_elem(1'b1);
        repeat (4) send_elem(1'b0);
        drain();

        // Rank above the limit saturates; zero extent on axis 1; mixed signs
        write_regs(3'd7, {16'd2, 16'd2, 16'd0, 16'd2},
                   {16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001},
                   {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF},
                   {32'h8000_0000, 32'h0000_0003}, {32'hFFFF_FFFF, 32'h0001_0000});
        send_elem(1'b1);
        repeat (5) send_elem(1'b0);
        send_elem(1'b1);
        repeat (3) send_elem(1'b0);
        drain();

        // All-ones registers: huge extents, index wrap
        write_regs(3'd2, '1, '1, '1, '1, '1);
        send_elem(1'b1);
        repeat (2) send_elem(1'b0);
        drain();

        // Random settings, mostly small extents so slices wrap often
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < PACKED_AXES; k++)
                counts[16*k +: 16] = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 5));
            write_regs(3'($urandom_range(0, 7)), counts, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            send_no_idle = (ph % 4 == 1) || (ph == 2);
            recv_no_idle = (ph % 4 == 1);
            // back-pressure: long sink hold-off while requests keep coming
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_elem($urandom_range(0, 7) == 0);
            drain();
        end

        $display("Checked %0d slice elements (%0d end-of-slice wraps) over %0d settings,",
                 elem_count, last_count, n_settings);
        $display("covering rank clamping, zero extents, negative strides and index wrap.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
